// ----- design/bmirq_pkg.sv -----
package bmirq_pkg;

   localparam int PRG_WINDOWS = 3;
   localparam int CHR_WINDOWS = 8;
   localparam int CHR_SEL_WIDTH = $clog2(CHR_WINDOWS);

   localparam int KIND_WIDTH = 2;
   localparam int ADDR_WIDTH = 16;
   localparam int DATA_WIDTH = 8;
   localparam int BANK_WIDTH = 8;
   localparam int COUNT_WIDTH = 16;
   localparam int TARGET_WIDTH = 3;
   localparam int MAPPED_WIDTH = 21;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [KIND_WIDTH-1:0] KIND_WRITE   = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_TICK    = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_CPU_MAP = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_PPU_MAP = 2'd3;

   localparam logic [TARGET_WIDTH-1:0] TARGET_NONE = 3'd0;
   localparam logic [TARGET_WIDTH-1:0] TARGET_PRAM = 3'd1;
   localparam logic [TARGET_WIDTH-1:0] TARGET_PROM = 3'd2;
   localparam logic [TARGET_WIDTH-1:0] TARGET_CROM = 3'd3;
   localparam logic [TARGET_WIDTH-1:0] TARGET_NT   = 3'd4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRG_BANK_MASK = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHR_BANK_MASK = 2'd1;

   localparam logic [3:0] PAGE_PRG0 = 4'h8;
   localparam logic [3:0] PAGE_CTRL = 4'h9;
   localparam logic [3:0] PAGE_PRG1 = 4'hA;
   localparam logic [3:0] PAGE_CHR  = 4'hB;
   localparam logic [3:0] PAGE_PRG2 = 4'hC;

   localparam logic [11:0] SUB_MIRROR     = 12'h001;
   localparam logic [11:0] SUB_IRQ_ENABLE = 12'h003;
   localparam logic [11:0] SUB_IRQ_ACK    = 12'h004;
   localparam logic [11:0] SUB_RELOAD_HI  = 12'h005;
   localparam logic [11:0] SUB_RELOAD_LO  = 12'h006;

   localparam logic [BANK_WIDTH-1:0] PRG_BANK2_RESET = 8'hFE;
   localparam logic [BANK_WIDTH-1:0] MASK_RESET      = 8'hFF;

   typedef struct packed {
      logic [KIND_WIDTH-1:0] kind;
      logic [ADDR_WIDTH-1:0] bus_addr;
      logic [DATA_WIDTH-1:0] write_data;
   } item_type;

   typedef struct packed {
      logic [PRG_WINDOWS-1:0][BANK_WIDTH-1:0] prg_banks;
      logic [CHR_WINDOWS-1:0][BANK_WIDTH-1:0] chr_banks;
      logic                                   mirror_select;
      logic [BANK_WIDTH-1:0]                  prg_bank_mask;
      logic [BANK_WIDTH-1:0]                  chr_bank_mask;
   } map_state_type;

   typedef struct packed {
      logic [TARGET_WIDTH-1:0] target;
      logic [MAPPED_WIDTH-1:0] mapped_addr;
      logic                    nametable_a10;
   } map_result_type;

endpackage

// ----- design/bmirq_state.sv -----
module bmirq_state (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 upd_valid,
   input  bmirq_pkg::item_type                  item,
   input  logic                                 csr_write,
   input  logic [bmirq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bmirq_pkg::DATA_WIDTH-1:0]      csr_write_data,
   output bmirq_pkg::map_state_type             map_state,
   output logic                                 irq_line_next
);

   logic [bmirq_pkg::PRG_WINDOWS-1:0][bmirq_pkg::BANK_WIDTH-1:0] prg_banks_ff, prg_banks_in;
   logic [bmirq_pkg::CHR_WINDOWS-1:0][bmirq_pkg::BANK_WIDTH-1:0] chr_banks_ff, chr_banks_in;
   logic                                  mirror_ff, mirror_in;
   logic                                  irq_enable_ff, irq_enable_in;
   logic                                  irq_line_ff, irq_line_in;
   logic [bmirq_pkg::COUNT_WIDTH-1:0]     irq_count_ff, irq_count_in;
   logic [bmirq_pkg::COUNT_WIDTH-1:0]     irq_reload_ff, irq_reload_in;
   logic [bmirq_pkg::BANK_WIDTH-1:0]      prg_mask_ff, prg_mask_in;
   logic [bmirq_pkg::BANK_WIDTH-1:0]      chr_mask_ff, chr_mask_in;
   logic [bmirq_pkg::COUNT_WIDTH-1:0]     count_dec;
   logic [3:0]                            page;
   logic [11:0]                           sub;
   logic                                  is_write;
   logic                                  is_tick;

   assign page      = item.bus_addr[15:12];
   assign sub       = item.bus_addr[11:0];
   assign is_write  = upd_valid && (item.kind == bmirq_pkg::KIND_WRITE);
   assign is_tick   = upd_valid && (item.kind == bmirq_pkg::KIND_TICK);
   assign count_dec = irq_count_ff - 1'b1;

   always_comb begin
      prg_banks_in  = prg_banks_ff;
      chr_banks_in  = chr_banks_ff;
      mirror_in     = mirror_ff;
      irq_enable_in = irq_enable_ff;
      irq_line_in   = irq_line_ff;
      irq_count_in  = irq_count_ff;
      irq_reload_in = irq_reload_ff;
      if (is_write) begin
         if (page == bmirq_pkg::PAGE_PRG0 && sub == 12'h000) begin
            prg_banks_in[0] = item.write_data;
         end else if (page == bmirq_pkg::PAGE_PRG1 && sub == 12'h000) begin
            prg_banks_in[1] = item.write_data;
         end else if (page == bmirq_pkg::PAGE_PRG2 && sub == 12'h000) begin
            prg_banks_in[2] = item.write_data;
         end else if (page == bmirq_pkg::PAGE_CHR
                      && sub[11:bmirq_pkg::CHR_SEL_WIDTH] == '0) begin
            chr_banks_in[sub[bmirq_pkg::CHR_SEL_WIDTH-1:0]] = item.write_data;
         end else if (page == bmirq_pkg::PAGE_CTRL) begin
            case (sub)
               bmirq_pkg::SUB_MIRROR: begin
                  mirror_in = item.write_data[7];
               end
               bmirq_pkg::SUB_IRQ_ENABLE: begin
                  irq_enable_in = item.write_data[7];
                  irq_line_in   = 1'b0;
               end
               bmirq_pkg::SUB_IRQ_ACK: begin
                  irq_count_in = irq_reload_ff;
                  irq_line_in  = 1'b0;
               end
               bmirq_pkg::SUB_RELOAD_HI: begin
                  irq_reload_in = {item.write_data, irq_reload_ff[7:0]};
               end
               bmirq_pkg::SUB_RELOAD_LO: begin
                  irq_reload_in = {irq_reload_ff[15:8], item.write_data};
               end
               default: begin
               end
            endcase
         end
      end else if (is_tick && irq_enable_ff) begin
         irq_count_in = count_dec;
         if (count_dec == '0) begin
            irq_line_in   = 1'b1;
            irq_enable_in = 1'b0;
         end
      end
   end

   always_comb begin
      prg_mask_in = prg_mask_ff;
      chr_mask_in = chr_mask_ff;
      if (csr_write) begin
         case (csr_index)
            bmirq_pkg::CSR_PRG_BANK_MASK: prg_mask_in = csr_write_data;
            bmirq_pkg::CSR_CHR_BANK_MASK: chr_mask_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_banks_ff[0] <= 8'd0;
         prg_banks_ff[1] <= 8'd1;
         prg_banks_ff[2] <= bmirq_pkg::PRG_BANK2_RESET;
         for (int i = 0; i < bmirq_pkg::CHR_WINDOWS; i++) begin
            chr_banks_ff[i] <= bmirq_pkg::BANK_WIDTH'(i);
         end
         mirror_ff     <= 1'b0;
         irq_enable_ff <= 1'b0;
         irq_line_ff   <= 1'b0;
         irq_count_ff  <= '0;
         irq_reload_ff <= '0;
         prg_mask_ff   <= bmirq_pkg::MASK_RESET;
         chr_mask_ff   <= bmirq_pkg::MASK_RESET;
      end else begin
         prg_banks_ff  <= prg_banks_in;
         chr_banks_ff  <= chr_banks_in;
         mirror_ff     <= mirror_in;
         irq_enable_ff <= irq_enable_in;
         irq_line_ff   <= irq_line_in;
         irq_count_ff  <= irq_count_in;
         irq_reload_ff <= irq_reload_in;
         prg_mask_ff   <= prg_mask_in;
         chr_mask_ff   <= chr_mask_in;
      end
   end

   assign map_state.prg_banks     = prg_banks_ff;
   assign map_state.chr_banks     = chr_banks_ff;
   assign map_state.mirror_select = mirror_ff;
   assign map_state.prg_bank_mask = prg_mask_ff;
   assign map_state.chr_bank_mask = chr_mask_ff;
   assign irq_line_next           = irq_line_in;

   // The counter reaching zero on a tick raises the line and stops counting.
   assert property (@(posedge clock) disable iff (reset)
      (is_tick && irq_enable_ff && irq_count_ff == 16'd1)
      |=> (irq_line_ff && !irq_enable_ff && irq_count_ff == '0))
      else $error("IRQ not raised when the counter reached zero");

   // Only a tick transaction can raise the line.
   assert property (@(posedge clock) disable iff (reset)
      $rose(irq_line_ff) |-> $past(is_tick))
      else $error("IRQ raised outside a tick");

   // An acknowledge with reload copies the latch and drops the line.
   assert property (@(posedge clock) disable iff (reset)
      (is_write && page == bmirq_pkg::PAGE_CTRL && sub == bmirq_pkg::SUB_IRQ_ACK)
      |=> (!irq_line_ff && irq_count_ff == $past(irq_reload_ff)))
      else $error("counter reload or acknowledge failed");

endmodule

// ----- design/bmirq_xlate.sv -----
module bmirq_xlate (
   input  bmirq_pkg::item_type       item,
   input  bmirq_pkg::map_state_type  map_state,
   output bmirq_pkg::map_result_type result
);

   logic [bmirq_pkg::BANK_WIDTH-1:0] prg_bank;
   logic [bmirq_pkg::BANK_WIDTH-1:0] chr_bank;
   logic [13:0]                      ppu_addr;
   logic                             nt_sel;

   assign ppu_addr = item.bus_addr[13:0];
   assign chr_bank = map_state.chr_banks[ppu_addr[12:10]] & map_state.chr_bank_mask;
   assign nt_sel   = map_state.mirror_select ? ppu_addr[11] : ppu_addr[10];

   always_comb begin
      case (item.bus_addr[14:13])
         2'd0:    prg_bank = map_state.prg_banks[0];
         2'd1:    prg_bank = map_state.prg_banks[1];
         2'd2:    prg_bank = map_state.prg_banks[2];
         default: prg_bank = 8'hFF;
      endcase
      prg_bank = prg_bank & map_state.prg_bank_mask;
   end

   always_comb begin
      result.target        = bmirq_pkg::TARGET_NONE;
      result.mapped_addr   = '0;
      result.nametable_a10 = 1'b0;
      case (item.kind)
         bmirq_pkg::KIND_CPU_MAP: begin
            if (item.bus_addr[15:13] == 3'd7) begin
               result.target      = bmirq_pkg::TARGET_PROM;
               result.mapped_addr = {map_state.prg_bank_mask, item.bus_addr[12:0]};
            end else if (item.bus_addr[15]) begin
               result.target      = bmirq_pkg::TARGET_PROM;
               result.mapped_addr = {prg_bank, item.bus_addr[12:0]};
            end else if (item.bus_addr[14:13] == 2'd3) begin
               result.target      = bmirq_pkg::TARGET_PRAM;
               result.mapped_addr = {8'd0, item.bus_addr[12:0]};
            end
         end
         bmirq_pkg::KIND_PPU_MAP: begin
            if (!ppu_addr[13]) begin
               result.target      = bmirq_pkg::TARGET_CROM;
               result.mapped_addr = {3'd0, chr_bank, ppu_addr[9:0]};
            end else begin
               result.target        = bmirq_pkg::TARGET_NT;
               result.mapped_addr   = {10'd0, nt_sel, ppu_addr[9:0]};
               result.nametable_a10 = nt_sel;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- design/bank_mapper_with_irq_counter.sv -----
// Bank mapper with a CPU-cycle IRQ counter. Every request transaction (a CPU
// register write, one CPU cycle tick, a CPU address or a PPU address) yields
// exactly one response transaction, in order. The block takes one transaction
// per clock unless a stalled response holds it: a request is captured in an
// input register, decoded and translated combinationally against the bank and
// counter registers, and the answer is held in a response register, from
// which it is presented. While the response register holds a stalled
// answer, one more request is still taken. The mask registers are written
// through the csr port, which is always ready.
module bank_mapper_with_irq_counter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [bmirq_pkg::KIND_WIDTH-1:0]      req_kind,
   input  logic [bmirq_pkg::ADDR_WIDTH-1:0]      req_bus_addr,
   input  logic [bmirq_pkg::DATA_WIDTH-1:0]      req_write_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_irq_active,
   output logic [bmirq_pkg::TARGET_WIDTH-1:0]    rsp_target,
   output logic [bmirq_pkg::MAPPED_WIDTH-1:0]    rsp_mapped_addr,
   output logic                                  rsp_nametable_a10,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bmirq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bmirq_pkg::DATA_WIDTH-1:0]      csr_write_data
);

   logic                          in_valid_ff, in_valid_in;
   bmirq_pkg::item_type           in_item_ff, in_item_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_irq_ff, rsp_irq_in;
   bmirq_pkg::map_result_type     rsp_result_ff, rsp_result_in;
   bmirq_pkg::map_state_type      map_state;
   bmirq_pkg::map_result_type     xlate_result;
   logic                          irq_line_next;
   logic                          advance;
   logic                          load_in;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign load_in   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = load_in || (in_valid_ff && !advance);
   assign in_item_in   = load_in ? bmirq_pkg::item_type'{kind: req_kind,
                                                         bus_addr: req_bus_addr,
                                                         write_data: req_write_data}
                                 : in_item_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign rsp_irq_in    = advance ? irq_line_next : rsp_irq_ff;
   assign rsp_result_in = advance ? xlate_result : rsp_result_ff;

   bmirq_state u_state (
      .clock          (clock),
      .reset          (reset),
      .upd_valid      (advance),
      .item           (in_item_ff),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .map_state      (map_state),
      .irq_line_next  (irq_line_next)
   );

   bmirq_xlate u_xlate (
      .item      (in_item_ff),
      .map_state (map_state),
      .result    (xlate_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff    <= in_item_in;
      rsp_irq_ff    <= rsp_irq_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_irq_active    = rsp_irq_ff;
   assign rsp_target        = rsp_result_ff.target;
   assign rsp_mapped_addr   = rsp_result_ff.mapped_addr;
   assign rsp_nametable_a10 = rsp_result_ff.nametable_a10;

endmodule

// ----- sim/tb_top.sv -----
module tb_top;

   localparam int CYCLE_LIMIT = 300000;
   localparam int FIELD_WIDTH = bmirq_pkg::MAPPED_WIDTH;

   typedef struct packed {
      logic                                irq_active;
      logic [bmirq_pkg::TARGET_WIDTH-1:0] target;
      logic [bmirq_pkg::MAPPED_WIDTH-1:0] mapped_addr;
      logic                                nametable_a10;
   } answer_type;

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_stall;
   logic [bmirq_pkg::KIND_WIDTH-1:0]      req_kind;
   logic [bmirq_pkg::ADDR_WIDTH-1:0]      req_bus_addr;
   logic [bmirq_pkg::DATA_WIDTH-1:0]      req_write_data;
   logic                                   rsp_valid;
   logic                                   rsp_stall;
   logic                                   rsp_irq_active;
   logic [bmirq_pkg::TARGET_WIDTH-1:0]    rsp_target;
   logic [bmirq_pkg::MAPPED_WIDTH-1:0]    rsp_mapped_addr;
   logic                                   rsp_nametable_a10;
   logic                                   csr_valid;
   logic                                   csr_ready;
   logic [bmirq_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [bmirq_pkg::DATA_WIDTH-1:0]      csr_write_data;

   // Mapper state as the testbench expects it to be.
   logic [bmirq_pkg::BANK_WIDTH-1:0]  prg_window_bank [bmirq_pkg::PRG_WINDOWS];
   logic [bmirq_pkg::BANK_WIDTH-1:0]  chr_window_bank [bmirq_pkg::CHR_WINDOWS];
   logic                              mirror_by_a11;
   logic                              irq_armed;
   logic [bmirq_pkg::COUNT_WIDTH-1:0] irq_counter;
   logic [bmirq_pkg::COUNT_WIDTH-1:0] irq_latch;
   logic                              irq_pin;
   logic [bmirq_pkg::BANK_WIDTH-1:0]  prg_mask;
   logic [bmirq_pkg::BANK_WIDTH-1:0]  chr_mask;

   answer_type pending_answers[$];
   int         mismatch_count;
   int         items_sent;
   int         cycle_count;
   int         burst_left;
   bit         no_gaps;
   bit         hold_pending;
   int         hold_len;

   bank_mapper_with_irq_counter u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_bus_addr      (req_bus_addr),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_irq_active    (rsp_irq_active),
      .rsp_target        (rsp_target),
      .rsp_mapped_addr   (rsp_mapped_addr),
      .rsp_nametable_a10 (rsp_nametable_a10),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bank_mapper_with_irq_counter test failed");
         $finish;
      end
   end

   function automatic answer_type apply_access(
         input logic [bmirq_pkg::KIND_WIDTH-1:0] kind,
         input logic [bmirq_pkg::ADDR_WIDTH-1:0] addr,
         input logic [bmirq_pkg::DATA_WIDTH-1:0] data);
      answer_type                       ans;
      logic [3:0]                       page;
      logic [11:0]                      sub;
      logic [13:0]                      ppu;
      logic [bmirq_pkg::BANK_WIDTH-1:0] bank;
      ans = '0;
      page = addr[15:12];
      sub = addr[11:0];
      ppu = addr[13:0];
      case (kind)
         bmirq_pkg::KIND_WRITE: begin
            if (page == bmirq_pkg::PAGE_PRG0 && sub == 12'h000) begin
               prg_window_bank[0] = data;
            end else if (page == bmirq_pkg::PAGE_PRG1 && sub == 12'h000) begin
               prg_window_bank[1] = data;
            end else if (page == bmirq_pkg::PAGE_PRG2 && sub == 12'h000) begin
               prg_window_bank[2] = data;
            end else if (page == bmirq_pkg::PAGE_CHR && sub < bmirq_pkg::CHR_WINDOWS) begin
               chr_window_bank[sub[bmirq_pkg::CHR_SEL_WIDTH-1:0]] = data;
            end else if (page == bmirq_pkg::PAGE_CTRL) begin
               case (sub)
                  bmirq_pkg::SUB_MIRROR: mirror_by_a11 = data[7];
                  bmirq_pkg::SUB_IRQ_ENABLE: begin
                     irq_armed = data[7];
                     irq_pin = 1'b0;
                  end
                  bmirq_pkg::SUB_IRQ_ACK: begin
                     irq_counter = irq_latch;
                     irq_pin = 1'b0;
                  end
                  bmirq_pkg::SUB_RELOAD_HI: irq_latch[15:8] = data;
                  bmirq_pkg::SUB_RELOAD_LO: irq_latch[7:0] = data;
                  default: ;
               endcase
            end
         end
         bmirq_pkg::KIND_TICK: begin
            if (irq_armed) begin
               irq_counter = irq_counter - 1'b1;
               if (irq_counter == '0) begin
                  irq_pin = 1'b1;
                  irq_armed = 1'b0;
               end
            end
         end
         bmirq_pkg::KIND_CPU_MAP: begin
            if (addr >= 16'hE000) begin
               ans.target = bmirq_pkg::TARGET_PROM;
               ans.mapped_addr = {prg_mask, addr[12:0]};
            end else if (addr >= 16'h8000) begin
               bank = prg_window_bank[addr[14:13]] & prg_mask;
               ans.target = bmirq_pkg::TARGET_PROM;
               ans.mapped_addr = {bank, addr[12:0]};
            end else if (addr >= 16'h6000) begin
               ans.target = bmirq_pkg::TARGET_PRAM;
               ans.mapped_addr = {8'h00, addr[12:0]};
            end
         end
         default: begin
            if (!ppu[13]) begin
               bank = chr_window_bank[ppu[12:10]] & chr_mask;
               ans.target = bmirq_pkg::TARGET_CROM;
               ans.mapped_addr = {3'b000, bank, ppu[9:0]};
            end else begin
               ans.nametable_a10 = mirror_by_a11 ? ppu[11] : ppu[10];
               ans.target = bmirq_pkg::TARGET_NT;
               ans.mapped_addr = {10'h000, ans.nametable_a10, ppu[9:0]};
            end
         end
      endcase
      ans.irq_active = irq_pin;
      return ans;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [FIELD_WIDTH-1:0] got,
                                input logic [FIELD_WIDTH-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   always @(posedge clock) begin : answer_check
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("response transaction with no request outstanding");
         end else begin
            want = pending_answers.pop_front();
            compare_field("irq_active", FIELD_WIDTH'(rsp_irq_active),
                          FIELD_WIDTH'(want.irq_active));
            compare_field("target", FIELD_WIDTH'(rsp_target), FIELD_WIDTH'(want.target));
            compare_field("mapped_addr", rsp_mapped_addr, want.mapped_addr);
            compare_field("nametable_a10", FIELD_WIDTH'(rsp_nametable_a10),
                          FIELD_WIDTH'(want.nametable_a10));
         end
      end
   end

   // The receiver either follows a random stall rate that changes from segment
   // to segment, or holds off completely for the requested hold length (hold_len).
   initial begin : rsp_stall_pattern
      int stall_pct;
      int seg_left;
      stall_pct = 0;
      seg_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
            hold_pending = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               case ($urandom_range(0, 4))
                  0, 1: stall_pct = 0;
                  2: stall_pct = 20;
                  3: stall_pct = 50;
                  default: stall_pct = 85;
               endcase
               seg_left = $urandom_range(10, 80);
            end
            seg_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   task automatic send_item(input logic [bmirq_pkg::KIND_WIDTH-1:0] kind,
                            input logic [bmirq_pkg::ADDR_WIDTH-1:0] addr,
                            input logic [bmirq_pkg::DATA_WIDTH-1:0] data);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_bus_addr <= addr;
      req_write_data <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_answers.push_back(apply_access(kind, addr, data));
      items_sent++;
      if (!no_gaps) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(10, 20)) @(posedge clock);
            end else begin
               repeat ($urandom_range(1, 5)) @(posedge clock);
            end
            burst_left = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic wait_all_answered();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic set_masks(input logic [bmirq_pkg::BANK_WIDTH-1:0] prg,
                            input logic [bmirq_pkg::BANK_WIDTH-1:0] chr);
      csr_valid <= 1'b1;
      csr_index <= bmirq_pkg::CSR_PRG_BANK_MASK;
      csr_write_data <= prg;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      prg_mask = prg;
      csr_index <= bmirq_pkg::CSR_CHR_BANK_MASK;
      csr_write_data <= chr;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      chr_mask = chr;
      csr_valid <= 1'b0;
   endtask

   function automatic void pick_access(output logic [bmirq_pkg::KIND_WIDTH-1:0] kind,
                                       output logic [bmirq_pkg::ADDR_WIDTH-1:0] addr,
                                       output logic [bmirq_pkg::DATA_WIDTH-1:0] data);
      int sel;
      sel = $urandom_range(0, 99);
      addr = 16'($urandom_range(0, 65535));
      data = 8'($urandom_range(0, 255));
      if (sel < 30) begin
         kind = bmirq_pkg::KIND_WRITE;
         case ($urandom_range(0, 8))
            0: addr = {bmirq_pkg::PAGE_PRG0, 12'h000};
            1: addr = {bmirq_pkg::PAGE_PRG1, 12'h000};
            2: addr = {bmirq_pkg::PAGE_PRG2, 12'h000};
            3: addr = {bmirq_pkg::PAGE_CHR,
                       12'($urandom_range(0, bmirq_pkg::CHR_WINDOWS - 1))};
            4: addr = {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_MIRROR};
            5: addr = {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_IRQ_ENABLE};
            6: addr = {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_IRQ_ACK};
            7: begin
               addr = {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_RELOAD_HI};
               if ($urandom_range(0, 3) != 0) data = 8'h00;
            end
            default: begin
               addr = {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_RELOAD_LO};
               if ($urandom_range(0, 3) != 0) data = 8'($urandom_range(0, 15));
            end
         endcase
      end else if (sel < 36) begin
         kind = bmirq_pkg::KIND_WRITE;
         if ($urandom_range(0, 1) == 0) begin
            addr[15:12] = 4'($urandom_range(8, 12));
            addr[11:0] = 12'($urandom_range(0, 15));
         end
      end else if (sel < 64) begin
         kind = bmirq_pkg::KIND_TICK;
      end else if (sel < 83) begin
         kind = bmirq_pkg::KIND_CPU_MAP;
      end else begin
         kind = bmirq_pkg::KIND_PPU_MAP;
      end
   endfunction

   task automatic send_irq_sequence();
      logic [bmirq_pkg::KIND_WIDTH-1:0] k;
      logic [bmirq_pkg::ADDR_WIDTH-1:0] a;
      logic [bmirq_pkg::DATA_WIDTH-1:0] d;
      logic [7:0]                       lo;
      int                               ticks;
      lo = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 12));
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_RELOAD_LO}, lo);
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_RELOAD_HI},
                ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : 8'h00);
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_IRQ_ACK},
                8'($urandom_range(0, 255)));
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_IRQ_ENABLE},
                {1'b1, 7'($urandom_range(0, 127))});
      ticks = lo + $urandom_range(0, 4);
      repeat (ticks) begin
         if ($urandom_range(0, 3) == 0) begin
            pick_access(k, a, d);
            send_item(k, a, d);
         end
         send_item(bmirq_pkg::KIND_TICK, 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 0) begin
         send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_IRQ_ENABLE},
                   8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_address_decode();
      send_item(bmirq_pkg::KIND_CPU_MAP, 16'h0000, 8'h00);
      send_item(bmirq_pkg::KIND_CPU_MAP, 16'h6000, 8'hFF);
      send_item(bmirq_pkg::KIND_CPU_MAP, 16'h7FFF, 8'h00);
      send_item(bmirq_pkg::KIND_CPU_MAP, 16'h8000, 8'h00);
      send_item(bmirq_pkg::KIND_CPU_MAP, 16'hBFFF, 8'h00);
      send_item(bmirq_pkg::KIND_CPU_MAP, 16'hDFFF, 8'h00);
      send_item(bmirq_pkg::KIND_CPU_MAP, 16'hFFFF, 8'h00);
      send_item(bmirq_pkg::KIND_PPU_MAP, 16'h0000, 8'h00);
      send_item(bmirq_pkg::KIND_PPU_MAP, 16'h1FFF, 8'h00);
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_MIRROR}, 8'h80);
      send_item(bmirq_pkg::KIND_PPU_MAP, 16'hEC00, 8'h00);
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CHR, 12'h008}, 8'hFF);
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_PRG1, 12'h000}, 8'hFF);
      send_item(bmirq_pkg::KIND_CPU_MAP, 16'hA000, 8'h00);
      wait_all_answered();
   endtask

   task automatic test_irq_counter();
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_RELOAD_LO}, 8'h02);
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_RELOAD_HI}, 8'h00);
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_IRQ_ACK}, 8'h00);
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_IRQ_ENABLE}, 8'h80);
      send_item(bmirq_pkg::KIND_TICK, 16'hFFFF, 8'hFF);
      send_item(bmirq_pkg::KIND_TICK, 16'h0000, 8'h00);
      send_item(bmirq_pkg::KIND_TICK, 16'h0000, 8'h00);
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_IRQ_ACK}, 8'h00);
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_RELOAD_LO}, 8'h00);
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_IRQ_ACK}, 8'h00);
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_IRQ_ENABLE}, 8'hFF);
      send_item(bmirq_pkg::KIND_TICK, 16'h0000, 8'h00);
      send_item(bmirq_pkg::KIND_WRITE, {bmirq_pkg::PAGE_CTRL, bmirq_pkg::SUB_IRQ_ENABLE}, 8'h00);
      wait_all_answered();
   endtask

   task automatic test_backpressure();
      logic [bmirq_pkg::KIND_WIDTH-1:0] k;
      logic [bmirq_pkg::ADDR_WIDTH-1:0] a;
      logic [bmirq_pkg::DATA_WIDTH-1:0] d;
      no_gaps = 1'b1;
      hold_len = 60;
      hold_pending = 1'b1;
      repeat (16) begin
         pick_access(k, a, d);
         send_item(k, a, d);
      end
      wait_all_answered();
      no_gaps = 1'b0;
   endtask

   task automatic test_random_traffic(input logic [bmirq_pkg::BANK_WIDTH-1:0] prg,
                                      input logic [bmirq_pkg::BANK_WIDTH-1:0] chr,
                                      input int count);
      logic [bmirq_pkg::KIND_WIDTH-1:0] k;
      logic [bmirq_pkg::ADDR_WIDTH-1:0] a;
      logic [bmirq_pkg::DATA_WIDTH-1:0] d;
      int                               stop_at;
      wait_all_answered();
      set_masks(prg, chr);
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         no_gaps = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) < 4) begin
            send_irq_sequence();
         end else begin
            repeat ($urandom_range(4, 16)) begin
               pick_access(k, a, d);
               send_item(k, a, d);
            end
         end
         if ($urandom_range(0, 19) == 0) begin
            wait_all_answered();
         end
      end
      no_gaps = 1'b0;
      wait_all_answered();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = bmirq_pkg::KIND_WRITE;
      req_bus_addr = '0;
      req_write_data = '0;
      csr_valid = 1'b0;
      csr_index = bmirq_pkg::CSR_PRG_BANK_MASK;
      csr_write_data = '0;
      prg_window_bank[0] = 8'h00;
      prg_window_bank[1] = 8'h01;
      prg_window_bank[2] = bmirq_pkg::PRG_BANK2_RESET;
      for (int i = 0; i < bmirq_pkg::CHR_WINDOWS; i++) chr_window_bank[i] = 8'(i);
      mirror_by_a11 = 1'b0;
      irq_armed = 1'b0;
      irq_counter = '0;
      irq_latch = '0;
      irq_pin = 1'b0;
      prg_mask = bmirq_pkg::MASK_RESET;
      chr_mask = bmirq_pkg::MASK_RESET;
      mismatch_count = 0;
      items_sent = 0;
      cycle_count = 0;
      burst_left = 0;
      no_gaps = 1'b0;
      hold_pending = 1'b0;
      hold_len = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      set_masks(bmirq_pkg::MASK_RESET, bmirq_pkg::MASK_RESET);
      test_address_decode();
      test_irq_counter();
      test_random_traffic(8'h00, 8'h00, 145);
      test_random_traffic(8'h0F, 8'h7F, 145);
      test_backpressure();
      test_random_traffic(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 145);
      test_random_traffic(8'hFF, 8'h00, 145);
      test_random_traffic(bmirq_pkg::MASK_RESET, bmirq_pkg::MASK_RESET, 145);
      repeat (8) @(posedge clock);
      if (pending_answers.size() != 0) begin
         report_mismatch("responses still outstanding at the end of the run");
      end
      if (mismatch_count == 0) begin
         $display("bank_mapper_with_irq_counter test passed");
      end else begin
         $display("bank_mapper_with_irq_counter test failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/bmirq_pkg.sv
design/bmirq_state.sv
design/bmirq_xlate.sv
design/bank_mapper_with_irq_counter.sv
sim/tb_top.sv
